@@ sv/prma_pkg.sv @@
// Shared types and constants for the period-to-rate moving average unit.
// No dependencies.
package prma_pkg;

  localparam int RATE_W     = 48;
  localparam int DUR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // 1e9 * 2^16: the numerator of the rate division, 46 bits wide
  localparam int RATE_NUM_W = 46;
  localparam logic [RATE_NUM_W-1:0] RATE_NUM = 46'd65536000000000;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  localparam logic [RATE_W-1:0] GOAL_RATE_RST = 48'd3932160;
  localparam logic [DUR_W-1:0]  INTERVAL_RST  = 32'd16666667;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOAL_RATE   = 2'd0,
    REG_INTERVAL_NS = 2'd1
  } cfg_reg_t;

endpackage

@@ sv/prma_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Uses prma_pkg only for the common import convention.
module prma_div import prma_pkg::*; #(
  parameter int NW = 52,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    nq_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DW:0] trial;
  logic        fits;

  // shift in the next numerator bit and try the subtraction
  assign trial = {rem_r, nq_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start && !busy_r) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
      nq_r   <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      nq_r  <= {nq_r[NW-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = nq_r;

endmodule

@@ sv/prma_ring.sv @@
// Rate history ring: single-port-write, single-port-read synchronous memory.
// Read data is registered, valid in the cycle after the read. Uses prma_pkg for RATE_W.
module prma_ring import prma_pkg::*; #(
  parameter int DEPTH = 10,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [RATE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [RATE_W-1:0] rdata
);

  logic [RATE_W-1:0] mem [DEPTH];
  logic [RATE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/period_to_rate_moving_average_unit.sv @@
// Period-to-rate moving average unit (top level).
// Depends on prma_pkg, prma_div and prma_ring.
//
// Usage:
//   Input channel (in_valid / in_stall / in_duration_ns): one transaction per
//   measured tick duration in ns. The unit takes one transaction at a time and
//   holds in_stall high while it works on it.
//   Output channel (out_valid / out_stall / out_*): one transaction per input,
//   with the instantaneous rate (Q32.16 Hz), the truncated mean over the
//   filled window, the tick number, the zero-duration flag and sleep/overrun.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register 0
//   is the goal rate, register 1 is interval_ns; other indexes are dropped.
//   cfg_ready is always high; write only while the unit is idle.
// Processing:
//   Each input passes S_READ, S_RATE, S_UPD, S_AVGGO and S_AVG; the next input
//   is taken only once the unit is back in S_IDLE. The divider is NW bits wide
//   (NW = max(46, 48 + clog2(depth+1)); 52 at a depth of 10). It is shared,
//   retires one quotient bit per cycle and runs twice per item: once for the
//   rate, once for the average. A zero duration skips the first pass and
//   S_RATE, and takes the goal rate as its instantaneous rate.
// Reset: rst_n is synchronous, active low; it empties the window, clears the
//   tick counter and restores the register defaults (60 Hz, 16666667 ns).
// Stall: a finished result waits in the output register while out_stall is
//   high; the next transaction is accepted and worked on meanwhile and waits
//   before the output register until the pending result is taken.
module period_to_rate_moving_average_unit import prma_pkg::*; #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DUR_W-1:0]     in_duration_ns,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [RATE_W-1:0]    out_inst_rate,
  output logic [RATE_W-1:0]    out_mean_rate,
  output logic [DUR_W-1:0]     out_tick_number,
  output logic                 out_zero_duration,
  output logic [DUR_W-1:0]     out_sleep_ns,
  output logic [DUR_W-1:0]     out_overrun_ns,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // window sizing: slot index, fill count and lossless running sum
  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = RATE_W + CW;
  // shared divider width covers both the rate numerator and the sum
  localparam int NW    = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
  localparam int QW    = (NW > RATE_W) ? NW : RATE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_RATE,
    S_UPD,
    S_AVGGO,
    S_AVG
  } state_t;

  // configuration registers
  logic [RATE_W-1:0] goal_rate_r;
  logic [DUR_W-1:0]  interval_r;

  // control state
  state_t           state_r, state_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [CW-1:0]    fill_r, fill_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [DUR_W-1:0] tick_r, tick_nxt;
  logic             out_valid_r, out_valid_nxt;

  // per-item work registers
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              zero_r, zero_nxt;
  logic [DUR_W-1:0]  sleep_r, sleep_nxt;
  logic [DUR_W-1:0]  overrun_r, overrun_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [RATE_W-1:0] old_r, old_nxt;

  // output registers
  logic [RATE_W-1:0] o_rate_r, o_rate_nxt;
  logic [RATE_W-1:0] o_avg_r, o_avg_nxt;
  logic [DUR_W-1:0]  o_tick_r, o_tick_nxt;
  logic              o_zero_r, o_zero_nxt;
  logic [DUR_W-1:0]  o_sleep_r, o_sleep_nxt;
  logic [DUR_W-1:0]  o_overrun_r, o_overrun_nxt;

  // ring and divider hookup
  logic              ring_we, ring_re;
  logic [RATE_W-1:0] ring_rdata;
  logic              div_start, div_busy;
  logic [NW-1:0]     div_num, div_quot;
  logic [DUR_W-1:0]  div_den;
  logic [QW-1:0]     q_ext;
  logic              window_full;

  prma_ring #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (rate_r),
    .re    (ring_re),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  prma_div #(
    .NW (NW),
    .DW (DUR_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign q_ext       = QW'(div_quot);
  assign window_full = (fill_r == CW'(WINDOW_DEPTH));

  // configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_rate_r <= GOAL_RATE_RST;
      interval_r  <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GOAL_RATE:   goal_rate_r <= cfg_data[RATE_W-1:0];
        REG_INTERVAL_NS: interval_r  <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // only the idle state takes a new transaction
  assign in_stall = (state_r != S_IDLE);

  // divider operands: rate pass in S_READ, average pass in S_AVGGO
  always_comb begin
    if (state_r == S_AVGGO) begin
      div_num = NW'(sum_r);
      div_den = DUR_W'(fill_r);
    end else begin
      div_num = NW'(RATE_NUM);
      div_den = dur_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    tick_nxt      = tick_r;
    dur_nxt       = dur_r;
    zero_nxt      = zero_r;
    sleep_nxt     = sleep_r;
    overrun_nxt   = overrun_r;
    rate_nxt      = rate_r;
    old_nxt       = old_r;
    o_rate_nxt    = o_rate_r;
    o_avg_nxt     = o_avg_r;
    o_tick_nxt    = o_tick_r;
    o_zero_nxt    = o_zero_r;
    o_sleep_nxt   = o_sleep_r;
    o_overrun_nxt = o_overrun_r;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    div_start     = 1'b0;

    // drop the pending result once the receiver takes it
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dur_nxt     = in_duration_ns;
          zero_nxt    = (in_duration_ns == '0);
          sleep_nxt   = (interval_r > in_duration_ns) ? interval_r - in_duration_ns : '0;
          overrun_nxt = (in_duration_ns >= interval_r) ? in_duration_ns - interval_r : '0;
          // fetch the entry about to be overwritten
          ring_re     = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        old_nxt = ring_rdata;
        if (zero_r) begin
          rate_nxt  = goal_rate_r;
          state_nxt = S_UPD;
        end else begin
          div_start = 1'b1;
          state_nxt = S_RATE;
        end
      end
      S_RATE: begin
        if (!div_busy) begin
          rate_nxt  = (q_ext > QW'(RATE_MAX)) ? RATE_MAX : q_ext[RATE_W-1:0];
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // retire the oldest rate once the window is full, then add the new one
        ring_we   = 1'b1;
        sum_nxt   = sum_r - (window_full ? SUM_W'(old_r) : '0) + SUM_W'(rate_r);
        slot_nxt  = (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        fill_nxt  = window_full ? fill_r : fill_r + 1'b1;
        tick_nxt  = tick_r + 1'b1;
        state_nxt = S_AVGGO;
      end
      S_AVGGO: begin
        div_start = 1'b1;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        // hold the result here until the output register is free
        if (!div_busy && (!out_valid_r || !out_stall)) begin
          o_rate_nxt    = rate_r;
          o_avg_nxt     = q_ext[RATE_W-1:0];
          o_tick_nxt    = tick_r;
          o_zero_nxt    = zero_r;
          o_sleep_nxt   = sleep_r;
          o_overrun_nxt = overrun_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dur_r       <= dur_nxt;
    zero_r      <= zero_nxt;
    sleep_r     <= sleep_nxt;
    overrun_r   <= overrun_nxt;
    rate_r      <= rate_nxt;
    old_r       <= old_nxt;
    o_rate_r    <= o_rate_nxt;
    o_avg_r     <= o_avg_nxt;
    o_tick_r    <= o_tick_nxt;
    o_zero_r    <= o_zero_nxt;
    o_sleep_r   <= o_sleep_nxt;
    o_overrun_r <= o_overrun_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_inst_rate     = o_rate_r;
  assign out_mean_rate     = o_avg_r;
  assign out_tick_number   = o_tick_r;
  assign out_zero_duration = o_zero_r;
  assign out_sleep_ns      = o_sleep_r;
  assign out_overrun_ns    = o_overrun_r;

  // fill count never passes the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(WINDOW_DEPTH))
    else $error("fill count beyond window depth");

  // write slot stays inside the ring
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= AW'(WINDOW_DEPTH - 1))
    else $error("write slot outside ring");

  // divider is never busy when a new transaction may start
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider busy in idle state");

  // a divider pass always starts while the divider is idle, and it is busy next cycle
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (!div_busy ##1 div_busy))
    else $error("divider start not taken");

endmodule
